@@ hw/rtl/seeprom_pkg.sv @@
// Package with the shared types, constants and helpers of the serial EEPROM command unit.
`timescale 1ns / 1ps
package seeprom_pkg;

  localparam int unsigned LINE_COUNT = 256;
  localparam int unsigned LINE_AW    = $clog2(LINE_COUNT);
  localparam int unsigned LINE_W     = 64;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [7:0] CMD_CHECK = 8'h00;
  localparam logic [7:0] CMD_READ  = 8'h04;
  localparam logic [7:0] CMD_WRITE = 8'h05;

  localparam logic [7:0] STAT_NO_DEV   = 8'h80;
  localparam logic [7:0] STAT_LEN_ERR  = 8'h40;
  localparam logic [7:0] TYPE_4K       = 8'h80;
  localparam logic [7:0] TYPE_16K      = 8'hC0;
  localparam logic [7:0] CHECK_RX_LEN  = 8'h03;

  localparam logic [APB_AW-3:0] REG_SAVE_KIND = '0;

  typedef enum logic [1:0] {
    KIND_AUTO = 2'd0,
    KIND_4K   = 2'd1,
    KIND_16K  = 2'd2,
    KIND_NONE = 2'd3
  } save_kind_e;

  typedef struct packed {
    logic [7:0]        cmd;
    logic [7:0]        rx_len;
    logic [7:0]        blk;
    logic [LINE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]        status;
    logic [7:0]        reply0;
    logic [LINE_W-1:0] payload;
  } result_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [7:0]        blk;
    logic [LINE_W-1:0] wdata;
  } store_req_t;

  function automatic logic [LINE_AW-1:0] line_of(logic [7:0] blk);
    logic [9:0] v;
    v = {2'b00, blk};
    if (v >= 10'(2 * LINE_COUNT)) v = v - 10'(2 * LINE_COUNT);
    if (v >= 10'(LINE_COUNT)) v = v - 10'(LINE_COUNT);
    return v[LINE_AW-1:0];
  endfunction

endpackage

@@ hw/rtl/seeprom_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module seeprom_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/seeprom_store.sv @@
// Line store: the line RAM plus per-line valid bits that make unwritten lines read as all ones.
`timescale 1ns / 1ps
module seeprom_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  seeprom_pkg::store_req_t          req_i,
  output logic [seeprom_pkg::LINE_W-1:0]   rd_line_o
);
  import seeprom_pkg::*;

  logic [LINE_AW-1:0]    line;
  logic [LINE_COUNT-1:0] line_valid_q;
  logic [LINE_COUNT-1:0] line_valid_d;
  logic                  rd_valid_q;
  logic [LINE_W-1:0]     ram_rdata;

  assign line = line_of(req_i.blk);

  always_comb begin
    line_valid_d = line_valid_q;
    if (req_i.wr) begin
      line_valid_d[line] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_valid_q <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      line_valid_q <= line_valid_d;
      if (req_i.rd) begin
        rd_valid_q <= line_valid_q[line];
      end
    end
  end

  seeprom_ram #(
    .Width(LINE_W),
    .Depth(LINE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr),
    .waddr_i(line),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.rd),
    .raddr_i(line),
    .rdata_o(ram_rdata)
  );

  assign rd_line_o = rd_valid_q ? ram_rdata : '1;

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr |=> line_valid_q[$past(line)])
    else $error("A written line was not marked valid.");

endmodule

@@ hw/rtl/seeprom_cfg.sv @@
// APB register block holding the save kind setting.
`timescale 1ns / 1ps
module seeprom_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [seeprom_pkg::APB_AW-1:0]  paddr,
  input  logic [seeprom_pkg::APB_DW-1:0]  pwdata,
  output logic [seeprom_pkg::APB_DW-1:0]  prdata,
  output logic                            pready,
  output seeprom_pkg::save_kind_e         save_kind_o
);
  import seeprom_pkg::*;

  save_kind_e          save_kind_q;
  save_kind_e          save_kind_d;
  logic [APB_AW-3:0]   reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    save_kind_d = save_kind_q;
    if (wr_en && reg_idx == REG_SAVE_KIND) begin
      save_kind_d = save_kind_e'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      save_kind_q <= KIND_AUTO;
    end else begin
      save_kind_q <= save_kind_d;
    end
  end

  assign prdata      = (reg_idx == REG_SAVE_KIND) ? {{(APB_DW-2){1'b0}}, save_kind_q} : '0;
  assign save_kind_o = save_kind_q;

endmodule

@@ hw/rtl/seeprom_reply.sv @@
// Reply formatter: builds the result of one command from the item, the setting and the read line.
`timescale 1ns / 1ps
module seeprom_reply (
  input  seeprom_pkg::item_t              item_i,
  input  seeprom_pkg::save_kind_e         save_kind_i,
  input  logic [seeprom_pkg::LINE_W-1:0]  rd_line_i,
  output seeprom_pkg::result_t            result_o
);
  import seeprom_pkg::*;

  logic [7:0] type_byte;
  logic       no_dev;
  logic [7:0] stat_err;
  logic [1:0] n;

  always_comb begin
    case (save_kind_i)
      KIND_16K: type_byte = TYPE_16K;
      default:  type_byte = TYPE_4K;
    endcase
    no_dev   = (save_kind_i == KIND_NONE);
    stat_err = item_i.rx_len | STAT_LEN_ERR;
    n        = stat_err[1:0];

    result_o.status  = item_i.rx_len;
    result_o.reply0  = item_i.blk;
    result_o.payload = item_i.write_data;

    case (item_i.cmd)
      CMD_CHECK: begin
        if (no_dev) begin
          result_o.status = item_i.rx_len | STAT_NO_DEV;
        end else if (item_i.rx_len != CHECK_RX_LEN) begin
          result_o.status = stat_err;
          if (n > 2'd0) result_o.reply0 = '0;
          if (n > 2'd1) result_o.payload[63:56] = type_byte;
          if (n > 2'd2) result_o.payload[55:48] = '0;
        end else begin
          result_o.reply0         = '0;
          result_o.payload[63:48] = {type_byte, 8'h00};
        end
      end
      CMD_READ: begin
        result_o.payload = rd_line_i;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/serial_eeprom_command_unit.sv @@
// Top level of the serial EEPROM command unit: stream channels, pipeline and output register.
//
// Channel   Direction  Transaction
// s_axis    in         one command: tuser = cmd, tdata = rx_len, block, write_data
// m_axis    out        one reply:   tdata = status_out, reply_byte0, payload_out
// APB       in/out     save_kind register at byte address 0
//
// One command per cycle is sustained while m_axis accepts replies; each reply passes through
// the registered read of the line RAM and then the output register.
// Reset clears the control state and all line valid bits, so every line reads as all ones.
// A stalled output holds its reply; a full pipeline drops s_axis_tready.
`timescale 1ns / 1ps
module serial_eeprom_command_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [79:0]                     s_axis_tdata,  // rx_len, block, write_data
  input  logic [7:0]                      s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [79:0]                     m_axis_tdata,  // status_out, reply_byte0, payload_out
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [seeprom_pkg::APB_AW-1:0]  paddr,
  input  logic [seeprom_pkg::APB_DW-1:0]  pwdata,
  output logic [seeprom_pkg::APB_DW-1:0]  prdata,
  output logic                            pready
);
  import seeprom_pkg::*;

  item_t       in_item;
  logic        in_acc;
  logic        s1_adv;
  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     result;
  store_req_t  store_req;
  logic [LINE_W-1:0] rd_line;
  save_kind_e  save_kind;

  assign in_item.cmd        = s_axis_tuser;
  assign in_item.rx_len     = s_axis_tdata[7:0];
  assign in_item.blk        = s_axis_tdata[15:8];
  assign in_item.write_data = s_axis_tdata[79:16];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign store_req.rd    = in_acc && (in_item.cmd == CMD_READ);
  assign store_req.wr    = in_acc && (in_item.cmd == CMD_WRITE);
  assign store_req.blk   = in_item.blk;
  assign store_req.wdata = in_item.write_data;

  seeprom_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_line_o(rd_line)
  );

  seeprom_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .save_kind_o(save_kind)
  );

  seeprom_reply u_reply (
    .item_i     (s1_item_q),
    .save_kind_i(save_kind),
    .rd_line_i  (rd_line),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.payload, out_q.reply0, out_q.status};

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("Input taken while the pipeline was stalled.");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("Accepted command did not reach the read stage.");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("Advanced command did not reach the output register.");

endmodule
